### src/rms_normalization_row_assert.svh
// assertion macros for the row rms normalisation block
// needs clk and arst_n in the scope of each use
`ifndef RMS_NORMALIZATION_ROW_ASSERT_SVH
`define RMS_NORMALIZATION_ROW_ASSERT_SVH
`ifndef SYNTH
`define RNR_ASSERT_SAME(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("assertion failed");
`define RNR_ASSERT_NEXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("assertion failed");
`else
`define RNR_ASSERT_SAME(lbl, ante, cons)
`define RNR_ASSERT_NEXT(lbl, ante, cons)
`endif
`endif

### src/rmsn_pkg.sv
// shared types and constants for the row rms normalisation block
// no dependencies
package rmsn_pkg;
	localparam int VAL_W    = 16;
	localparam int EPS_W    = 24;
	localparam logic [EPS_W-1:0] EPS_RESET = 24'd168;
	localparam int SQ_W     = 31;
	localparam int MS_W     = 32;
	localparam int RCP_W    = 57;
	localparam int ROOT_W   = 29;
	localparam int SR_W     = 58;
	localparam int RCP_STEPS  = 57;
	localparam int SQRT_STEPS = 29;
	localparam int STEP_W   = 6;

	typedef struct packed {
		logic store;
		logic div_init;
		logic div_step;
		logic rcp_init;
		logic rcp_step;
		logic sqrt_init;
		logic sqrt_step;
		logic load_out;
		logic row_clr;
	} cmd_t;
endpackage

### src/rmsn_dp.sv
// datapath: element memory, square sum, dividers, square root, scaling pipeline
// depends on rmsn_pkg
module rmsn_dp #(
	parameter int MAX_ROW_LENGTH = 64,
	parameter int CNT_W = 7,
	parameter int AW = 6,
	parameter int ACC_W = 38
) (
	input  logic clk,
	input  logic arst_n,
	input  rmsn_pkg::cmd_t cmd,
	input  logic [AW-1:0] addr,
	input  logic [CNT_W-1:0] count,
	input  logic [31:0] in_data,
	input  logic cfg_wr_en,
	input  logic [rmsn_pkg::EPS_W-1:0] cfg_wr_data,
	output logic [rmsn_pkg::VAL_W-1:0] out_data
);
	import rmsn_pkg::*;

	logic [31:0] mem [MAX_ROW_LENGTH];
	logic [EPS_W-1:0] eps_q;
	logic [ACC_W-1:0] acc_q;
	logic [CNT_W:0] rem1_q;
	logic [ACC_W-1:0] quo1_q;
	logic [CNT_W:0] rem1_sh;
	logic [MS_W:0] rem2_q;
	logic [RCP_W-1:0] quo2_q;
	logic [MS_W:0] rem2_sh;
	logic [MS_W-1:0] rem2_keep_q;
	logic [MS_W-1:0] ms;
	logic [SR_W-1:0] sn_q, sres_q, sbit_q, ssum;
	logic signed [VAL_W-1:0] v_in;
	logic [SQ_W-1:0] sq;
	logic [31:0] rd_s1;
	logic [31:0] prod_s2;
	logic neg_s2, neg_s3;
	logic [59:0] p_s3;
	logic [59:0] rsum;
	logic [31:0] q;
	logic [VAL_W:0] va, wa;
	logic [VAL_W-1:0] ma, mb;
	logic [VAL_W-1:0] out_q;

	assign v_in = signed'(in_data[15:0]);
	assign sq = SQ_W'(unsigned'(32'(v_in * v_in)));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			eps_q <= EPS_RESET;
			acc_q <= '0;
		end else begin
			if (cfg_wr_en) eps_q <= cfg_wr_data;
			if (cmd.row_clr) acc_q <= '0;
			else if (cmd.store) acc_q <= acc_q + ACC_W'(sq);
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.store) mem[addr] <= in_data;
		rd_s1 <= mem[addr];
	end

	// mean square: restoring division of the sum by the count
	assign rem1_sh = {rem1_q[CNT_W-1:0], quo1_q[ACC_W-1]};
	assign ms = MS_W'(quo1_q[SQ_W-1:0]) + MS_W'(eps_q);
	// reciprocal 2^56 / ms
	assign rem2_sh = {rem2_q[MS_W-1:0], quo2_q[RCP_W-1]};
	assign ssum = sres_q + sbit_q;

	always_ff @(posedge clk) begin
		if (cmd.div_init) begin
			rem1_q <= '0;
			quo1_q <= acc_q;
		end else if (cmd.div_step) begin
			if (rem1_sh >= {1'b0, count}) begin
				rem1_q <= rem1_sh - {1'b0, count};
				quo1_q <= {quo1_q[ACC_W-2:0], 1'b1};
			end else begin
				rem1_q <= rem1_sh;
				quo1_q <= {quo1_q[ACC_W-2:0], 1'b0};
			end
		end
		if (cmd.rcp_init) begin
			rem2_q <= '0;
			quo2_q <= {1'b1, (RCP_W-1)'(0)};
		end else if (cmd.rcp_step) begin
			if (rem2_sh >= {1'b0, rem2_keep_q}) begin
				rem2_q <= rem2_sh - {1'b0, rem2_keep_q};
				quo2_q <= {quo2_q[RCP_W-2:0], 1'b1};
			end else begin
				rem2_q <= rem2_sh;
				quo2_q <= {quo2_q[RCP_W-2:0], 1'b0};
			end
		end
		if (cmd.sqrt_init) begin
			sn_q <= SR_W'(quo2_q);
			sres_q <= '0;
			sbit_q <= SR_W'(1) << 56;
		end else if (cmd.sqrt_step) begin
			if (sn_q >= ssum) begin
				sn_q <= sn_q - ssum;
				sres_q <= (sres_q >> 1) + sbit_q;
			end else begin
				sres_q <= sres_q >> 1;
			end
			sbit_q <= sbit_q >> 2;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.rcp_init) rem2_keep_q <= (ms == '0) ? MS_W'(1) : ms;
	end

	// scaling pipeline
	assign va = {rd_s1[15], rd_s1[15:0]};
	assign wa = {rd_s1[31], rd_s1[31:16]};
	assign ma = rd_s1[15] ? VAL_W'(-va) : rd_s1[15:0];
	assign mb = rd_s1[31] ? VAL_W'(-wa) : rd_s1[31:16];
	assign rsum = p_s3 + (60'd1 << 27);
	assign q = rsum[59:28];

	always_ff @(posedge clk) begin
		prod_s2 <= 32'(ma) * 32'(mb);
		neg_s2 <= rd_s1[15] ^ rd_s1[31];
		p_s3 <= 60'(prod_s2[30:0]) * 60'(sres_q[ROOT_W-1:0]);
		neg_s3 <= neg_s2;
		if (cmd.load_out) begin
			if (neg_s3) out_q <= (q > 32'd32768) ? 16'h8000 : VAL_W'(-q[16:0]);
			else out_q <= (q > 32'd32767) ? 16'h7fff : q[15:0];
		end
	end

	assign out_data = out_q;
endmodule

### src/rmsn_ctrl.sv
// controller: row load, division, root and emission sequencing
// depends on rmsn_pkg
module rmsn_ctrl #(
	parameter int MAX_ROW_LENGTH = 64,
	parameter int CNT_W = 7,
	parameter int AW = 6,
	parameter int ACC_W = 38
) (
	input  logic clk,
	input  logic arst_n,
	input  logic in_valid,
	input  logic in_last,
	output logic in_ready,
	output logic out_valid,
	output logic out_last,
	input  logic out_ready,
	output rmsn_pkg::cmd_t cmd,
	output logic [AW-1:0] addr,
	output logic [CNT_W-1:0] count
);
	import rmsn_pkg::*;

	typedef enum logic [3:0] {
		S_LOAD, S_DINIT, S_DIV, S_RINIT, S_RCP, S_SINIT, S_SQRT,
		S_RD, S_P1, S_P2, S_FIN, S_OUT
	} state_t;

	state_t state_q;
	logic [CNT_W-1:0] count_q, idx_q;
	logic [STEP_W-1:0] step_q;
	logic valid_q, last_q;
	logic acc_in, room;

	assign in_ready = (state_q == S_LOAD);
	assign acc_in = in_valid && in_ready;
	assign room = count_q < CNT_W'(MAX_ROW_LENGTH);

	always_comb begin
		cmd = '0;
		cmd.store = acc_in && room;
		cmd.div_init = (state_q == S_DINIT);
		cmd.div_step = (state_q == S_DIV);
		cmd.rcp_init = (state_q == S_RINIT);
		cmd.rcp_step = (state_q == S_RCP);
		cmd.sqrt_init = (state_q == S_SINIT);
		cmd.sqrt_step = (state_q == S_SQRT);
		cmd.load_out = (state_q == S_FIN);
		cmd.row_clr = (state_q == S_OUT) && out_ready && last_q;
	end

	assign addr = (state_q == S_LOAD) ? count_q[AW-1:0] : idx_q[AW-1:0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_LOAD;
			count_q <= '0;
			idx_q <= '0;
			step_q <= '0;
			valid_q <= 1'b0;
			last_q <= 1'b0;
		end else begin
			unique case (state_q)
				S_LOAD: begin
					if (acc_in) begin
						if (room) count_q <= count_q + 1'b1;
						if (in_last) state_q <= S_DINIT;
					end
				end
				S_DINIT: begin
					step_q <= STEP_W'(ACC_W - 1);
					state_q <= S_DIV;
				end
				S_DIV: begin
					step_q <= step_q - 1'b1;
					if (step_q == '0) state_q <= S_RINIT;
				end
				S_RINIT: begin
					step_q <= STEP_W'(RCP_STEPS - 1);
					state_q <= S_RCP;
				end
				S_RCP: begin
					step_q <= step_q - 1'b1;
					if (step_q == '0) state_q <= S_SINIT;
				end
				S_SINIT: begin
					step_q <= STEP_W'(SQRT_STEPS - 1);
					state_q <= S_SQRT;
				end
				S_SQRT: begin
					step_q <= step_q - 1'b1;
					if (step_q == '0) begin
						idx_q <= '0;
						state_q <= S_RD;
					end
				end
				S_RD: state_q <= S_P1;
				S_P1: state_q <= S_P2;
				S_P2: state_q <= S_FIN;
				S_FIN: begin
					valid_q <= 1'b1;
					last_q <= (idx_q + 1'b1) == count_q;
					state_q <= S_OUT;
				end
				S_OUT: begin
					if (out_ready) begin
						valid_q <= 1'b0;
						if (last_q) begin
							count_q <= '0;
							state_q <= S_LOAD;
						end else begin
							idx_q <= idx_q + 1'b1;
							state_q <= S_RD;
						end
					end
				end
				default: state_q <= S_LOAD;
			endcase
		end
	end

	assign out_valid = valid_q;
	assign out_last = last_q;
	assign count = count_q;
endmodule

### src/rms_normalization_row.sv
// top level of the row rms normalisation block
// depends on rmsn_pkg, rmsn_ctrl, rmsn_dp and rms_normalization_row_assert.svh
//
// Input stream s_*: one row element per transaction, tdata = {weight, value},
// both signed Q4.12; tlast marks the final element of a row. Elements beyond
// MAX_ROW_LENGTH are dropped (the row still closes on tlast).
// After tlast the block computes the mean square by a restoring divider,
// the reciprocal 2^56/ms and its integer square root, each preceded by a
// set-up state. Each element is then read back, multiplied by value,
// weight and the root in a three stage pipeline and presented on m_* as a
// Q4.12 saturated result, one element at a time: the next element is read
// only after the receiver has taken the current result. m_tlast marks the
// last result of the row. A stalled receiver holds the result in the output
// register; no new input is taken until the row is out. Reset clears the
// count, the sum and sets epsilon to 168. epsilon is written through
// cfg_wr_en / cfg_wr_data; the user must do so only while the block is idle,
// the block itself does not enforce it.
`include "rms_normalization_row_assert.svh"
module rms_normalization_row #(
	parameter int MAX_ROW_LENGTH = 64
) (
	input  logic clk,
	input  logic arst_n,
	input  logic s_tvalid,
	output logic s_tready,
	input  logic [31:0] s_tdata, // sample_value [15:0], scale_weight [31:16]
	input  logic s_tlast,
	output logic m_tvalid,
	input  logic m_tready,
	output logic [15:0] m_tdata, // normalized_value [15:0]
	output logic m_tlast,
	input  logic cfg_wr_en,
	input  logic [rmsn_pkg::EPS_W-1:0] cfg_wr_data
);
	import rmsn_pkg::*;

	localparam int CNT_W = $clog2(MAX_ROW_LENGTH + 1);
	localparam int AW = (MAX_ROW_LENGTH > 1) ? $clog2(MAX_ROW_LENGTH) : 1;
	localparam int ACC_W = SQ_W + CNT_W;

	cmd_t cmd;
	logic [AW-1:0] addr;
	logic [CNT_W-1:0] count;

	rmsn_ctrl #(
		.MAX_ROW_LENGTH(MAX_ROW_LENGTH), .CNT_W(CNT_W), .AW(AW), .ACC_W(ACC_W)
	) u_ctrl (
		.clk(clk), .arst_n(arst_n),
		.in_valid(s_tvalid), .in_last(s_tlast), .in_ready(s_tready),
		.out_valid(m_tvalid), .out_last(m_tlast), .out_ready(m_tready),
		.cmd(cmd), .addr(addr), .count(count)
	);

	rmsn_dp #(
		.MAX_ROW_LENGTH(MAX_ROW_LENGTH), .CNT_W(CNT_W), .AW(AW), .ACC_W(ACC_W)
	) u_dp (
		.clk(clk), .arst_n(arst_n), .cmd(cmd), .addr(addr), .count(count),
		.in_data(s_tdata), .cfg_wr_en(cfg_wr_en), .cfg_wr_data(cfg_wr_data),
		.out_data(m_tdata)
	);

	`RNR_ASSERT_SAME(a_no_overlap, m_tvalid, !s_tready)
	`RNR_ASSERT_NEXT(a_row_done_reload, m_tvalid && m_tready && m_tlast, s_tready && count == '0)
	`RNR_ASSERT_SAME(a_store_on_accept, cmd.store, s_tvalid && s_tready)
endmodule

### bench/rms_normalization_row_tb.sv
// self-checking bench for rms_normalization_row: directed and random rows,
// predicted in-bench and compared per result; depends on rmsn_pkg and the rtl
`timescale 1ns / 1ps
module rms_normalization_row_tb;
	import rmsn_pkg::*;

	localparam int ROW_CAP = 64;

	typedef struct {
		logic [15:0] value;
		logic        last;
	} norm_result_t;

	logic clk;
	logic arst_n;
	logic s_tvalid;
	logic s_tready;
	logic [31:0] s_tdata; // sample_value [15:0], scale_weight [31:16]
	logic s_tlast;
	logic m_tvalid;
	logic m_tready;
	logic [15:0] m_tdata; // normalized_value [15:0]
	logic m_tlast;
	logic cfg_wr_en;
	logic [EPS_W-1:0] cfg_wr_data;

	norm_result_t norm_q[$];
	logic [15:0] held_values[$];
	logic [15:0] held_weights[$];
	longint unsigned sq_total;
	logic [EPS_W-1:0] eps_shadow;
	bit src_gaps;
	bit sink_gaps;
	int hold_cycles;
	int errors;
	int results_seen;
	int rows_sent;
	int elems_sent;

	rms_normalization_row #(.MAX_ROW_LENGTH(ROW_CAP)) u_dut (
		.clk(clk), .arst_n(arst_n),
		.s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tlast(s_tlast),
		.m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tlast(m_tlast),
		.cfg_wr_en(cfg_wr_en), .cfg_wr_data(cfg_wr_data)
	);

	initial begin
		clk = 1'b0;
		forever #2 clk = ~clk;
	end

	initial begin
		#8_000_000;
		$display("FAIL");
		$finish;
	end

	function automatic longint unsigned int_sqrt(longint unsigned n);
		longint unsigned res;
		longint unsigned b;
		res = 0;
		b = 64'd1 << 62;
		while (b > n)
			b >>= 2;
		while (b != 0) begin
			if (n >= res + b) begin
				n -= res + b;
				res = (res >> 1) + b;
			end else begin
				res >>= 1;
			end
			b >>= 2;
		end
		return res;
	endfunction

	function automatic logic [15:0] weighted_norm(logic signed [15:0] v, logic signed [15:0] w,
			longint unsigned root);
		longint a;
		longint b;
		longint unsigned q;
		a = v;
		b = w;
		q = ((a < 0 ? -a : a) * root * (b < 0 ? -b : b) + (64'd1 << 27)) >> 28;
		if ((a < 0) != (b < 0)) begin
			if (q > 32768)
				q = 32768;
			return 16'(-longint'(q));
		end
		if (q > 32767)
			q = 32767;
		return 16'(q);
	endfunction

	// mirrors one accepted element, queues the row results on its last element
	task automatic predict_element(logic [15:0] v, logic [15:0] w, logic row_end);
		longint unsigned mean_sq;
		longint unsigned root;
		longint sv;
		int n;
		if (held_values.size() < ROW_CAP) begin
			sv = $signed(v);
			held_values.push_back(v);
			held_weights.push_back(w);
			sq_total += longint'(sv * sv);
		end
		if (row_end) begin
			n = held_values.size();
			mean_sq = sq_total / n + eps_shadow;
			if (mean_sq == 0)
				mean_sq = 1;
			root = int_sqrt((64'd1 << 56) / mean_sq);
			for (int i = 0; i < n; i++)
				norm_q.push_back('{weighted_norm(held_values[i], held_weights[i], root),
					i == n - 1});
			held_values.delete();
			held_weights.delete();
			sq_total = 0;
			rows_sent++;
		end
	endtask

	task automatic send_element(logic [15:0] v, logic [15:0] w, logic row_end);
		if (src_gaps)
			while ($urandom_range(99) < 28) begin
				s_tvalid <= 1'b0;
				@(negedge clk);
			end
		s_tvalid <= 1'b1;
		s_tdata  <= {w, v};
		s_tlast  <= row_end;
		do @(posedge clk); while (!s_tready);
		predict_element(v, w, row_end);
		elems_sent++;
		@(negedge clk);
	endtask

	task automatic stop_sending();
		s_tvalid <= 1'b0;
		@(negedge clk);
	endtask

	task automatic wait_drained();
		stop_sending();
		while (norm_q.size() != 0)
			@(negedge clk);
		repeat (20) @(negedge clk);
	endtask

	task automatic write_epsilon(logic [EPS_W-1:0] eps);
		wait_drained();
		cfg_wr_en   <= 1'b1;
		cfg_wr_data <= eps;
		@(negedge clk);
		cfg_wr_en   <= 1'b0;
		eps_shadow = eps;
		@(negedge clk);
	endtask

	task automatic send_random_row(int len);
		for (int i = 0; i < len; i++)
			if ($urandom_range(3) == 0)
				send_element(16'($urandom_range(8191) - 4096), 16'($urandom), i == len - 1);
			else
				send_element(16'($urandom), 16'($urandom), i == len - 1);
	endtask

	// single-element rows at the field extremes and saturation, and one three-element row
	task automatic test_extremes();
		send_element(16'h7fff, 16'h7fff, 1'b1);
		send_element(16'h8000, 16'h8000, 1'b1);
		send_element(16'h8000, 16'h7fff, 1'b1);
		send_element(16'h7fff, 16'h8000, 1'b1);
		send_element(16'h0001, 16'h1000, 1'b1);
		send_element(16'h0001, 16'h7fff, 1'b0);
		send_element(16'hffff, 16'h8000, 1'b0);
		send_element(16'h8000, 16'h0001, 1'b1);
	endtask

	// zero mean square with zero epsilon takes the largest root
	task automatic test_zero_mean();
		write_epsilon('0);
		send_element(16'h0000, 16'h7fff, 1'b1);
		send_element(16'h0000, 16'h8000, 1'b0);
		send_element(16'h0000, 16'h1234, 1'b1);
	endtask

	// elements past the row capacity are dropped, tlast still closes the row
	task automatic test_row_overflow();
		write_epsilon({EPS_W{1'b1}});
		send_random_row(ROW_CAP + 3);
	endtask

	// receiver held off while rows keep coming, then a full drain pause
	task automatic test_backpressure();
		hold_cycles = 400;
		send_random_row(6);
		send_random_row(5);
		send_random_row(3);
		wait_drained();
	endtask

	task automatic test_random_rows();
		int len;
		int sent_before;
		write_epsilon(EPS_RESET);
		sent_before = elems_sent;
		while (elems_sent - sent_before < 70) begin
			case ($urandom_range(9))
				0: write_epsilon(EPS_W'($urandom));
				1: len = $urandom_range(ROW_CAP, 20);
				default: len = $urandom_range(8, 1);
			endcase
			if (elems_sent - sent_before > 15 && elems_sent - sent_before < 55) begin
				src_gaps  = 1'b0;
				sink_gaps = 1'b0;
			end else begin
				src_gaps  = 1'b1;
				sink_gaps = 1'b1;
			end
			send_random_row(len);
		end
		src_gaps  = 1'b1;
		sink_gaps = 1'b1;
	endtask

	always @(negedge clk) begin
		if (hold_cycles > 0) begin
			m_tready <= 1'b0;
			hold_cycles <= hold_cycles - 1;
		end else begin
			m_tready <= !(sink_gaps && $urandom_range(99) < 28);
		end
	end

	always @(posedge clk) begin
		if (arst_n && m_tvalid && m_tready) begin
			results_seen++;
			if (norm_q.size() == 0) begin
				$display("%0t unexpected result: actual value %h last %b", $realtime,
					m_tdata, m_tlast);
				errors++;
			end else begin
				if (m_tdata !== norm_q[0].value) begin
					$display("%0t value mismatch: expected %h actual %h", $realtime,
						norm_q[0].value, m_tdata);
					errors++;
				end
				if (m_tlast !== norm_q[0].last) begin
					$display("%0t last mismatch: expected %b actual %b", $realtime,
						norm_q[0].last, m_tlast);
					errors++;
				end
				void'(norm_q.pop_front());
			end
		end
	end

	initial begin
		arst_n      = 1'b0;
		s_tvalid    = 1'b0;
		s_tdata     = '0;
		s_tlast     = 1'b0;
		m_tready    = 1'b0;
		cfg_wr_en   = 1'b0;
		cfg_wr_data = '0;
		hold_cycles = 0;
		src_gaps    = 1'b1;
		sink_gaps   = 1'b1;
		sq_total    = 0;
		eps_shadow  = EPS_RESET;
		errors       = 0;
		results_seen = 0;
		rows_sent    = 0;
		elems_sent   = 0;
		repeat (11) @(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);
		test_extremes();
		test_zero_mean();
		test_row_overflow();
		test_backpressure();
		test_random_rows();
		wait_drained();
		repeat (200) @(negedge clk);
		if (norm_q.size() != 0) begin
			$display("%0t %0d expected results never arrived", $realtime, norm_q.size());
			errors++;
		end
		$display("covered %0d rows, %0d elements, %0d results, %0d errors", rows_sent,
			elems_sent, results_seen, errors);
		$display("incl. saturation, zero mean square, row overflow and receiver hold-off");
		if (errors == 0)
			$display("PASS");
		else
			$display("FAIL");
		$finish;
	end
endmodule
